### rtl/mcalu_pkg.sv
`timescale 1ns / 1ps

package mcalu_pkg;

  // operation codes
  typedef enum logic [4:0] {
    FN_CLR    = 5'd0,
    FN_INC    = 5'd1,
    FN_DEC    = 5'd2,
    FN_NEG    = 5'd3,
    FN_TST    = 5'd4,
    FN_COM    = 5'd5,
    FN_ASR    = 5'd6,
    FN_ASL    = 5'd7,
    FN_ADC    = 5'd8,
    FN_SBC    = 5'd9,
    FN_SXT    = 5'd10,
    FN_ROR    = 5'd11,
    FN_ROL    = 5'd12,
    FN_SWAB   = 5'd13,
    FN_MOV    = 5'd14,
    FN_ADD    = 5'd15,
    FN_SUB    = 5'd16,
    FN_CMP    = 5'd17,
    FN_BIT    = 5'd18,
    FN_BIS    = 5'd19,
    FN_BIC    = 5'd20,
    FN_XOR    = 5'd21,
    FN_CCSET  = 5'd22,
    FN_BRANCH = 5'd23
  } func_t;

  // branch test terms
  typedef enum logic [2:0] {
    BR_Z      = 3'd0,
    BR_N      = 3'd1,
    BR_C      = 3'd2,
    BR_V      = 3'd3,
    BR_NXV    = 3'd4,
    BR_ZONXV  = 3'd5,
    BR_CORZ   = 3'd6,
    BR_ALWAYS = 3'd7
  } br_kind_t;

  // condition code bit positions
  localparam int unsigned CC_N = 3;
  localparam int unsigned CC_Z = 2;
  localparam int unsigned CC_V = 1;
  localparam int unsigned CC_C = 0;

  localparam logic [15:0] WORD_SIGN = 16'h8000;
  localparam logic [15:0] WORD_MASK = 16'hFFFF;
  localparam logic [15:0] BYTE_SIGN = 16'h0080;
  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  // decoded item passed from front to back
  typedef struct packed {
    func_t       func;
    logic        bm;
    logic        wb;
    logic        nz;
    logic [15:0] s;
    logic [15:0] d;
    logic [15:0] dst;
    logic        dreg;
    logic [3:0]  ccm;
    logic        ccv;
    br_kind_t    kind;
    logic        sense;
  } cmd_t;

  // finished result item
  typedef struct packed {
    logic [15:0] result;
    logic        write_back;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic        flag_c;
    logic        branch_taken;
  } res_t;

  // operations that honour the byte-mode bit
  function automatic logic byte_capable(input logic [4:0] f);
    logic ok;
    ok = (f <= 5'd9) || (f == 5'd11) || (f == 5'd12) || (f == 5'd14) ||
         ((f >= 5'd17) && (f <= 5'd20));
    return ok;
  endfunction

endpackage

### rtl/minicomputer_alu_condition_codes_top.sv
`timescale 1ns / 1ps

// 16-bit ALU with N, Z, V and C condition codes. Items go in through a queue
// style port (push/full) and results come out the same way (pop/empty), one
// result per item, in order. An item is decoded on entry, held in a two-entry
// command queue and executed by the back end, which keeps the four codes and
// writes each result into a two-entry result buffer. Throughput is one item
// per clock while results are popped as they come; an accepted item is
// registered in the command queue and then executed out of it into the
// result buffer, from which it shows on the output to be popped. The codes
// clear on reset and carry from each item to the next.

module minicomputer_alu_condition_codes_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [4:0]  in_func,
  input  logic        in_byte_op,
  input  logic [15:0] in_src_value,
  input  logic [15:0] in_dst_value,
  input  logic        in_dst_is_register,
  input  logic [3:0]  in_cc_mask,
  input  logic        in_cc_value,
  input  logic [2:0]  in_branch_kind,
  input  logic        in_branch_sense,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_result,
  output logic        out_write_back,
  output logic        out_flag_n,
  output logic        out_flag_z,
  output logic        out_flag_v,
  output logic        out_flag_c,
  output logic        out_branch_taken
);

  mcalu_pkg::cmd_t cmd_dec;
  mcalu_pkg::cmd_t cmd_q;
  mcalu_pkg::res_t res;
  logic            q_empty;
  logic            q_pop;

  // decode
  mcalu_front u_front (
    .in_byte_op         (in_byte_op),
    .in_func            (in_func),
    .in_src_value       (in_src_value),
    .in_dst_value       (in_dst_value),
    .in_dst_is_register (in_dst_is_register),
    .in_cc_mask         (in_cc_mask),
    .in_cc_value        (in_cc_value),
    .in_branch_kind     (in_branch_kind),
    .in_branch_sense    (in_branch_sense),
    .cmd                (cmd_dec)
  );

  // command queue between decode and execute
  mcalu_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .cmd_in  (cmd_dec),
    .full    (in_full),
    .pop     (q_pop),
    .cmd_out (cmd_q),
    .empty   (q_empty)
  );

  // execute and result buffer
  mcalu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_q),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res_out   (res),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

  assign out_result       = res.result;
  assign out_write_back   = res.write_back;
  assign out_flag_n       = res.flag_n;
  assign out_flag_z       = res.flag_z;
  assign out_flag_v       = res.flag_v;
  assign out_flag_c       = res.flag_c;
  assign out_branch_taken = res.branch_taken;

endmodule

### rtl/mcalu_front.sv
`timescale 1ns / 1ps

module mcalu_front (
  input  logic                  in_byte_op,
  input  logic [4:0]            in_func,
  input  logic [15:0]           in_src_value,
  input  logic [15:0]           in_dst_value,
  input  logic                  in_dst_is_register,
  input  logic [3:0]            in_cc_mask,
  input  logic                  in_cc_value,
  input  logic [2:0]            in_branch_kind,
  input  logic                  in_branch_sense,
  output mcalu_pkg::cmd_t       cmd
);

  logic        bm;
  logic [15:0] msk;
  logic        wb;
  logic        nz;

  // byte mode only where the operation has a byte form
  assign bm  = in_byte_op & mcalu_pkg::byte_capable(in_func);
  assign msk = bm ? mcalu_pkg::BYTE_MASK : mcalu_pkg::WORD_MASK;

  // classify: write-back and whether N and Z follow the result
  always_comb begin
    wb = 1'b1;
    nz = 1'b1;
    case (mcalu_pkg::func_t'(in_func))
      mcalu_pkg::FN_TST, mcalu_pkg::FN_CMP, mcalu_pkg::FN_BIT: begin
        wb = 1'b0;
      end
      mcalu_pkg::FN_SXT, mcalu_pkg::FN_SWAB: begin
        nz = 1'b0;
      end
      mcalu_pkg::FN_CLR, mcalu_pkg::FN_INC, mcalu_pkg::FN_DEC, mcalu_pkg::FN_NEG,
      mcalu_pkg::FN_COM, mcalu_pkg::FN_ASR, mcalu_pkg::FN_ASL, mcalu_pkg::FN_ADC,
      mcalu_pkg::FN_SBC, mcalu_pkg::FN_ROR, mcalu_pkg::FN_ROL, mcalu_pkg::FN_MOV,
      mcalu_pkg::FN_ADD, mcalu_pkg::FN_SUB, mcalu_pkg::FN_BIS, mcalu_pkg::FN_BIC,
      mcalu_pkg::FN_XOR: begin
        wb = 1'b1;
      end
      default: begin
        // ccset, branch and unused codes
        wb = 1'b0;
        nz = 1'b0;
      end
    endcase
  end

  // pack the decoded item
  always_comb begin
    cmd.func  = mcalu_pkg::func_t'(in_func);
    cmd.bm    = bm;
    cmd.wb    = wb;
    cmd.nz    = nz;
    cmd.s     = in_src_value & msk;
    cmd.d     = in_dst_value & msk;
    cmd.dst   = in_dst_value;
    cmd.dreg  = in_dst_is_register;
    cmd.ccm   = in_cc_mask;
    cmd.ccv   = in_cc_value;
    cmd.kind  = mcalu_pkg::br_kind_t'(in_branch_kind);
    cmd.sense = in_branch_sense;
  end

endmodule

### rtl/mcalu_cmd_q.sv
`timescale 1ns / 1ps

module mcalu_cmd_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mcalu_pkg::cmd_t cmd_in,
  output logic            full,
  input  logic            pop,
  output mcalu_pkg::cmd_t cmd_out,
  output logic            empty
);

  mcalu_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign cmd_out = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### rtl/mcalu_back.sv
`timescale 1ns / 1ps

module mcalu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mcalu_pkg::cmd_t cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output mcalu_pkg::res_t res_out,
  output logic            res_empty,
  input  logic            res_pop
);

  logic [3:0]      cc_r, cc_nxt;
  mcalu_pkg::res_t rbuf_r [2];
  logic            rwr_ptr_r, rwr_ptr_nxt;
  logic            rrd_ptr_r, rrd_ptr_nxt;
  logic [1:0]      rcnt_r, rcnt_nxt;
  logic            exec;
  logic            do_rpop;

  logic [15:0] msk, sbv, d, s, r, res;
  logic [16:0] sum;
  logic        n, z, v, c, t, taken;

  // execute when an item waits and the result buffer has room
  assign exec      = ~cmd_empty & (rcnt_r != 2'd2);
  assign cmd_pop   = exec;
  assign res_empty = (rcnt_r == 2'd0);
  assign do_rpop   = res_pop & ~res_empty;
  assign res_out   = rbuf_r[rrd_ptr_r];

  assign msk = cmd.bm ? mcalu_pkg::BYTE_MASK : mcalu_pkg::WORD_MASK;
  assign sbv = cmd.bm ? mcalu_pkg::BYTE_SIGN : mcalu_pkg::WORD_SIGN;
  assign d   = cmd.d;
  assign s   = cmd.s;
  assign sum = {1'b0, s} + {1'b0, d};

  // operation and new codes
  always_comb begin
    n     = cc_r[mcalu_pkg::CC_N];
    z     = cc_r[mcalu_pkg::CC_Z];
    v     = cc_r[mcalu_pkg::CC_V];
    c     = cc_r[mcalu_pkg::CC_C];
    r     = 16'h0000;
    t     = 1'b0;
    taken = 1'b0;
    case (cmd.func)
      mcalu_pkg::FN_CLR: begin
        v = 1'b0;
        c = 1'b0;
      end
      mcalu_pkg::FN_INC: begin
        r = (d + 16'd1) & msk;
        v = (r == sbv);
      end
      mcalu_pkg::FN_DEC: begin
        r = (d - 16'd1) & msk;
        v = (r == (sbv - 16'd1));
      end
      mcalu_pkg::FN_NEG: begin
        r = (16'd0 - d) & msk;
        v = (r == sbv);
        c = (r != 16'd0);
      end
      mcalu_pkg::FN_TST: begin
        r = d;
        v = 1'b0;
        c = 1'b0;
      end
      mcalu_pkg::FN_COM: begin
        r = ~d & msk;
        v = 1'b0;
        c = 1'b1;
      end
      mcalu_pkg::FN_ASR: begin
        r = (d >> 1) | (d & sbv);
        c = d[0];
        v = (|(r & sbv)) ^ c;
      end
      mcalu_pkg::FN_ASL: begin
        r = (d << 1) & msk;
        c = |(d & sbv);
        v = (|(r & sbv)) ^ c;
      end
      mcalu_pkg::FN_ADC: begin
        r = (d + {15'd0, c}) & msk;
        v = c & (d == (sbv - 16'd1));
        c = c & (d == msk);
      end
      mcalu_pkg::FN_SBC: begin
        r = (d - {15'd0, c}) & msk;
        v = c & (d == sbv);
        c = c & (d == 16'd0);
      end
      mcalu_pkg::FN_SXT: begin
        r = n ? 16'hFFFF : 16'h0000;
        z = ~n;
        v = 1'b0;
      end
      mcalu_pkg::FN_ROR: begin
        r = (d >> 1) | (c ? sbv : 16'h0000);
        c = d[0];
        v = (|(r & sbv)) ^ c;
      end
      mcalu_pkg::FN_ROL: begin
        r = ((d << 1) & msk) | {15'd0, c};
        c = |(d & sbv);
        v = (|(r & sbv)) ^ c;
      end
      mcalu_pkg::FN_SWAB: begin
        r = {d[7:0], d[15:8]};
        n = r[7];
        z = (r[7:0] == 8'h00);
        v = 1'b0;
        c = 1'b0;
      end
      mcalu_pkg::FN_MOV: begin
        r = s;
        v = 1'b0;
      end
      mcalu_pkg::FN_ADD: begin
        r = sum[15:0] & msk;
        c = ({1'b0, msk} < sum);
        v = |(~(s ^ d) & (s ^ r) & sbv);
      end
      mcalu_pkg::FN_SUB: begin
        r = (d - s) & msk;
        c = (d < s);
        v = |((d ^ s) & (d ^ r) & sbv);
      end
      mcalu_pkg::FN_CMP: begin
        r = (s - d) & msk;
        c = (s < d);
        v = |((s ^ d) & (s ^ r) & sbv);
      end
      mcalu_pkg::FN_BIT: begin
        r = s & d;
        v = 1'b0;
      end
      mcalu_pkg::FN_BIS: begin
        r = d | s;
        v = 1'b0;
      end
      mcalu_pkg::FN_BIC: begin
        r = d & ~s & msk;
        v = 1'b0;
      end
      mcalu_pkg::FN_XOR: begin
        r = (s ^ d) & msk;
        v = 1'b0;
      end
      mcalu_pkg::FN_CCSET: begin
        if (cmd.ccm[mcalu_pkg::CC_N]) n = cmd.ccv;
        if (cmd.ccm[mcalu_pkg::CC_Z]) z = cmd.ccv;
        if (cmd.ccm[mcalu_pkg::CC_V]) v = cmd.ccv;
        if (cmd.ccm[mcalu_pkg::CC_C]) c = cmd.ccv;
      end
      mcalu_pkg::FN_BRANCH: begin
        case (cmd.kind)
          mcalu_pkg::BR_Z:     t = z;
          mcalu_pkg::BR_N:     t = n;
          mcalu_pkg::BR_C:     t = c;
          mcalu_pkg::BR_V:     t = v;
          mcalu_pkg::BR_NXV:   t = n ^ v;
          mcalu_pkg::BR_ZONXV: t = z | (n ^ v);
          mcalu_pkg::BR_CORZ:  t = c | z;
          default:             t = 1'b1;
        endcase
        taken = (t == cmd.sense);
      end
      default: begin
        r = 16'h0000;
      end
    endcase
    // N and Z from the result
    if (cmd.nz) begin
      n = |(r & sbv);
      z = ((r & msk) == 16'h0000);
    end
  end

  // write-back value, byte forms merge or sign-extend
  always_comb begin
    res = 16'h0000;
    if (cmd.wb) begin
      if (cmd.bm) begin
        if ((cmd.func == mcalu_pkg::FN_MOV) && cmd.dreg) begin
          res = {{8{r[7]}}, r[7:0]};
        end else begin
          res = {cmd.dst[15:8], r[7:0]};
        end
      end else begin
        res = r;
      end
    end
  end

  // result buffer control
  always_comb begin
    cc_nxt      = exec ? {n, z, v, c} : cc_r;
    rwr_ptr_nxt = rwr_ptr_r ^ exec;
    rrd_ptr_nxt = rrd_ptr_r ^ do_rpop;
    rcnt_nxt    = rcnt_r + {1'b0, exec} - {1'b0, do_rpop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r      <= 4'h0;
      rwr_ptr_r <= 1'b0;
      rrd_ptr_r <= 1'b0;
      rcnt_r    <= 2'd0;
    end else begin
      cc_r      <= cc_nxt;
      rwr_ptr_r <= rwr_ptr_nxt;
      rrd_ptr_r <= rrd_ptr_nxt;
      rcnt_r    <= rcnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (exec) begin
      rbuf_r[rwr_ptr_r] <= '{result:       res,
                             write_back:   cmd.wb,
                             flag_n:       n,
                             flag_z:       z,
                             flag_v:       v,
                             flag_c:       c,
                             branch_taken: taken};
    end
  end

endmodule

### test/tb_minicomputer_alu_condition_codes_top.sv
`timescale 1ns / 1ps

module tb_minicomputer_alu_condition_codes_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_RANDOM    = 700;
  localparam int unsigned DRAIN_EVERY = 150;
  localparam int unsigned SETTLE      = 8;
  localparam logic [4:0]  FN_NOP_LAST = 5'd31;

  // one alu operation as pushed into the block
  typedef struct {
    logic [4:0]  func;
    logic        byte_op;
    logic [15:0] src;
    logic [15:0] dst;
    logic        dreg;
    logic [3:0]  ccm;
    logic        ccv;
    logic [2:0]  kind;
    logic        sense;
    bit          drain;
  } alu_item_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [4:0]  in_func = '0;
  logic        in_byte_op = 1'b0;
  logic [15:0] in_src_value = '0;
  logic [15:0] in_dst_value = '0;
  logic        in_dst_is_register = 1'b0;
  logic [3:0]  in_cc_mask = '0;
  logic        in_cc_value = 1'b0;
  logic [2:0]  in_branch_kind = '0;
  logic        in_branch_sense = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_result;
  logic        out_write_back;
  logic        out_flag_n;
  logic        out_flag_z;
  logic        out_flag_v;
  logic        out_flag_c;
  logic        out_branch_taken;

  alu_item_t       op_pending[$];
  mcalu_pkg::res_t alu_expected[$];
  alu_item_t       op_on_port;
  logic [3:0]      cc_state = '0;
  int unsigned     n_accepted = 0;
  int unsigned     n_errors = 0;
  int unsigned     n_cycles = 0;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;

  minicomputer_alu_condition_codes_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_byte_op         (in_byte_op),
    .in_src_value       (in_src_value),
    .in_dst_value       (in_dst_value),
    .in_dst_is_register (in_dst_is_register),
    .in_cc_mask         (in_cc_mask),
    .in_cc_value        (in_cc_value),
    .in_branch_kind     (in_branch_kind),
    .in_branch_sense    (in_branch_sense),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_result         (out_result),
    .out_write_back     (out_write_back),
    .out_flag_n         (out_flag_n),
    .out_flag_z         (out_flag_z),
    .out_flag_v         (out_flag_v),
    .out_flag_c         (out_flag_c),
    .out_branch_taken   (out_branch_taken)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // idling mix: sender light then heavy, then no idling at all
  assign send_idle_pct = (n_accepted < 240) ? 36 : (n_accepted < 480) ? 70 : 0;
  assign recv_idle_pct = (n_accepted < 240) ? 70 : (n_accepted < 480) ? 36 : 0;

  // expected result of one operation, advancing the held condition codes
  function automatic mcalu_pkg::res_t alu_predict(input alu_item_t it);
    logic            bm;
    logic [15:0]     msk, sb, d, s, r;
    logic [16:0]     sum;
    logic            n, z, v, c, wb, nz, term;
    mcalu_pkg::res_t o;
    case (it.func)
      mcalu_pkg::FN_CLR, mcalu_pkg::FN_INC, mcalu_pkg::FN_DEC, mcalu_pkg::FN_NEG,
      mcalu_pkg::FN_TST, mcalu_pkg::FN_COM, mcalu_pkg::FN_ASR, mcalu_pkg::FN_ASL,
      mcalu_pkg::FN_ADC, mcalu_pkg::FN_SBC, mcalu_pkg::FN_ROR, mcalu_pkg::FN_ROL,
      mcalu_pkg::FN_MOV, mcalu_pkg::FN_CMP, mcalu_pkg::FN_BIT, mcalu_pkg::FN_BIS,
      mcalu_pkg::FN_BIC: bm = it.byte_op;
      default: bm = 1'b0;
    endcase
    msk  = bm ? mcalu_pkg::BYTE_MASK : mcalu_pkg::WORD_MASK;
    sb   = bm ? mcalu_pkg::BYTE_SIGN : mcalu_pkg::WORD_SIGN;
    d    = it.dst & msk;
    s    = it.src & msk;
    n    = cc_state[mcalu_pkg::CC_N];
    z    = cc_state[mcalu_pkg::CC_Z];
    v    = cc_state[mcalu_pkg::CC_V];
    c    = cc_state[mcalu_pkg::CC_C];
    r    = '0;
    sum  = '0;
    wb   = 1'b1;
    nz   = 1'b1;
    term = 1'b0;
    o    = '0;
    case (it.func)
      mcalu_pkg::FN_CLR: begin
        r = '0; v = 1'b0; c = 1'b0;
      end
      mcalu_pkg::FN_INC: begin
        r = (d + 16'd1) & msk; v = (r == sb);
      end
      mcalu_pkg::FN_DEC: begin
        r = (d - 16'd1) & msk; v = (r == sb - 16'd1);
      end
      mcalu_pkg::FN_NEG: begin
        r = (16'd0 - d) & msk; v = (r == sb); c = (r != 16'd0);
      end
      mcalu_pkg::FN_TST: begin
        r = d; wb = 1'b0; v = 1'b0; c = 1'b0;
      end
      mcalu_pkg::FN_COM: begin
        r = ~d & msk; v = 1'b0; c = 1'b1;
      end
      mcalu_pkg::FN_ASR: begin
        r = (d >> 1) | (d & sb); c = d[0]; v = ((r & sb) != 16'd0) ^ c;
      end
      mcalu_pkg::FN_ASL: begin
        r = (d << 1) & msk; c = ((d & sb) != 16'd0); v = ((r & sb) != 16'd0) ^ c;
      end
      mcalu_pkg::FN_ADC: begin
        r = (d + {15'd0, c}) & msk;
        v = c && (d == sb - 16'd1);
        c = c && (d == msk);
      end
      mcalu_pkg::FN_SBC: begin
        r = (d - {15'd0, c}) & msk;
        v = c && (d == sb);
        c = c && (d == 16'd0);
      end
      mcalu_pkg::FN_SXT: begin
        r = n ? 16'hFFFF : 16'h0000; z = !n; v = 1'b0; nz = 1'b0;
      end
      mcalu_pkg::FN_ROR: begin
        r = (d >> 1) | (c ? sb : 16'd0); c = d[0]; v = ((r & sb) != 16'd0) ^ c;
      end
      mcalu_pkg::FN_ROL: begin
        r = ((d << 1) & msk) | {15'd0, c};
        c = ((d & sb) != 16'd0);
        v = ((r & sb) != 16'd0) ^ c;
      end
      mcalu_pkg::FN_SWAB: begin
        r = {d[7:0], d[15:8]};
        n = r[7]; z = (r[7:0] == 8'd0); v = 1'b0; c = 1'b0; nz = 1'b0;
      end
      mcalu_pkg::FN_MOV: begin
        r = s; v = 1'b0;
      end
      mcalu_pkg::FN_ADD: begin
        sum = {1'b0, s} + {1'b0, d};
        r   = sum[15:0] & msk;
        c   = (sum > {1'b0, msk});
        v   = ((~(s ^ d) & (s ^ r) & sb) != 16'd0);
      end
      mcalu_pkg::FN_SUB: begin
        r = (d - s) & msk; c = (d < s); v = (((d ^ s) & (d ^ r) & sb) != 16'd0);
      end
      mcalu_pkg::FN_CMP: begin
        r = (s - d) & msk; c = (s < d); v = (((s ^ d) & (s ^ r) & sb) != 16'd0);
        wb = 1'b0;
      end
      mcalu_pkg::FN_BIT: begin
        r = s & d; v = 1'b0; wb = 1'b0;
      end
      mcalu_pkg::FN_BIS: begin
        r = d | s; v = 1'b0;
      end
      mcalu_pkg::FN_BIC: begin
        r = d & ~s & msk; v = 1'b0;
      end
      mcalu_pkg::FN_XOR: begin
        r = (s ^ d) & msk; v = 1'b0;
      end
      mcalu_pkg::FN_CCSET: begin
        if (it.ccm[mcalu_pkg::CC_N]) n = it.ccv;
        if (it.ccm[mcalu_pkg::CC_Z]) z = it.ccv;
        if (it.ccm[mcalu_pkg::CC_V]) v = it.ccv;
        if (it.ccm[mcalu_pkg::CC_C]) c = it.ccv;
        wb = 1'b0; nz = 1'b0;
      end
      mcalu_pkg::FN_BRANCH: begin
        case (it.kind)
          mcalu_pkg::BR_Z:     term = z;
          mcalu_pkg::BR_N:     term = n;
          mcalu_pkg::BR_C:     term = c;
          mcalu_pkg::BR_V:     term = v;
          mcalu_pkg::BR_NXV:   term = n ^ v;
          mcalu_pkg::BR_ZONXV: term = z | (n ^ v);
          mcalu_pkg::BR_CORZ:  term = c | z;
          default:             term = 1'b1;
        endcase
        o.branch_taken = (term == it.sense);
        wb = 1'b0; nz = 1'b0;
      end
      default: begin
        wb = 1'b0; nz = 1'b0;
      end
    endcase
    if (nz) begin
      n = ((r & sb) != 16'd0);
      z = ((r & msk) == 16'd0);
    end
    // byte results merge into the old high byte, except a byte move into a register
    if (wb) begin
      if (bm && it.func == mcalu_pkg::FN_MOV && it.dreg) o.result = {{8{r[7]}}, r[7:0]};
      else if (bm) o.result = {it.dst[15:8], r[7:0]};
      else o.result = r;
    end
    o.write_back = wb;
    o.flag_n     = n;
    o.flag_z     = z;
    o.flag_v     = v;
    o.flag_c     = c;
    cc_state     = {n, z, v, c};
    return o;
  endfunction

  // directed item with neutral defaults for the side fields
  function automatic alu_item_t mk_op(input logic [4:0] f, input logic b,
                                      input logic [15:0] s, input logic [15:0] d);
    alu_item_t it;
    it.func    = f;
    it.byte_op = b;
    it.src     = s;
    it.dst     = d;
    it.dreg    = 1'b1;
    it.ccm     = 4'hF;
    it.ccv     = 1'b1;
    it.kind    = mcalu_pkg::BR_ALWAYS;
    it.sense   = 1'b0;
    it.drain   = 1'b0;
    return it;
  endfunction

  // operand biased towards sign and carry boundaries
  function automatic logic [15:0] rand_operand();
    logic [15:0] x;
    x = 16'($urandom);
    case ($urandom_range(0, 9))
      0: x = 16'h0000;
      1: x = 16'hFFFF;
      2: x = 16'h8000;
      3: x = 16'h7FFF;
      4: x[7:0] = 8'h80;
      5: x[7:0] = 8'h7F;
      6: x[7:0] = 8'hFF;
      7: x[7:0] = 8'h00;
      default: ;
    endcase
    return x;
  endfunction

  function automatic alu_item_t rand_op();
    alu_item_t   it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) it.func = 5'($urandom_range(24, 31));
    else if (pick < 15) it.func = mcalu_pkg::FN_CCSET;
    else if (pick < 30) it.func = mcalu_pkg::FN_BRANCH;
    else it.func = 5'($urandom_range(0, 21));
    it.byte_op = 1'($urandom_range(0, 1));
    it.src     = rand_operand();
    it.dst     = rand_operand();
    it.dreg    = 1'($urandom_range(0, 1));
    it.ccm     = 4'($urandom_range(0, 15));
    it.ccv     = 1'($urandom_range(0, 1));
    it.kind    = 3'($urandom_range(0, 7));
    it.sense   = 1'($urandom_range(0, 1));
    it.drain   = 1'b0;
    return it;
  endfunction

  // driver: one item on the ports, held until the block takes it
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        alu_expected.push_back(alu_predict(op_on_port));
        n_accepted++;
      end
      if (!(in_push && in_full)) begin
        if (op_pending.size() > 0 && !(op_pending[0].drain && alu_expected.size() > 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          op_on_port = op_pending.pop_front();
          in_push            <= 1'b1;
          in_func            <= op_on_port.func;
          in_byte_op         <= op_on_port.byte_op;
          in_src_value       <= op_on_port.src;
          in_dst_value       <= op_on_port.dst;
          in_dst_is_register <= op_on_port.dreg;
          in_cc_mask         <= op_on_port.ccm;
          in_cc_value        <= op_on_port.ccv;
          in_branch_kind     <= op_on_port.kind;
          in_branch_sense    <= op_on_port.sense;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // monitor: compare each popped result against the oldest prediction
  always @(posedge clk) begin
    mcalu_pkg::res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (alu_expected.size() == 0) begin
          $error("result item with nothing expected: result %0h", out_result);
          n_errors++;
        end else begin
          want = alu_expected.pop_front();
          check_field("result", want.result, out_result);
          check_field("write_back", {15'd0, want.write_back}, {15'd0, out_write_back});
          check_field("flag_n", {15'd0, want.flag_n}, {15'd0, out_flag_n});
          check_field("flag_z", {15'd0, want.flag_z}, {15'd0, out_flag_z});
          check_field("flag_v", {15'd0, want.flag_v}, {15'd0, out_flag_v});
          check_field("flag_c", {15'd0, want.flag_c}, {15'd0, out_flag_c});
          check_field("branch_taken", {15'd0, want.branch_taken},
                      {15'd0, out_branch_taken});
        end
      end
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_minicomputer_alu_condition_codes_top: FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    alu_item_t it;
    // directed: every operation, boundary operands, byte forms and corner cases
    op_pending.push_back(mk_op(mcalu_pkg::FN_CLR, 1'b0, 16'h0000, 16'hFFFF));
    op_pending.push_back(mk_op(mcalu_pkg::FN_INC, 1'b1, 16'h0000, 16'h127F));
    op_pending.push_back(mk_op(mcalu_pkg::FN_INC, 1'b0, 16'h0000, 16'h7FFF));
    op_pending.push_back(mk_op(mcalu_pkg::FN_DEC, 1'b0, 16'h0000, 16'h8000));
    op_pending.push_back(mk_op(mcalu_pkg::FN_NEG, 1'b0, 16'h0000, 16'h8000));
    op_pending.push_back(mk_op(mcalu_pkg::FN_TST, 1'b1, 16'h0000, 16'hFF80));
    op_pending.push_back(mk_op(mcalu_pkg::FN_COM, 1'b0, 16'h0000, 16'h0000));
    op_pending.push_back(mk_op(mcalu_pkg::FN_ASR, 1'b0, 16'h0000, 16'h8001));
    op_pending.push_back(mk_op(mcalu_pkg::FN_ASL, 1'b1, 16'h0000, 16'hABC0));
    op_pending.push_back(mk_op(mcalu_pkg::FN_ADC, 1'b0, 16'h0000, 16'hFFFF));
    op_pending.push_back(mk_op(mcalu_pkg::FN_SBC, 1'b1, 16'h0000, 16'h5500));
    op_pending.push_back(mk_op(mcalu_pkg::FN_SXT, 1'b1, 16'h0000, 16'h1234));
    op_pending.push_back(mk_op(mcalu_pkg::FN_ROR, 1'b0, 16'h0000, 16'h0001));
    op_pending.push_back(mk_op(mcalu_pkg::FN_ROL, 1'b1, 16'h0000, 16'h0080));
    op_pending.push_back(mk_op(mcalu_pkg::FN_SWAB, 1'b1, 16'h0000, 16'h00FF));
    // byte move into a register sign-extends, into memory keeps the high byte
    op_pending.push_back(mk_op(mcalu_pkg::FN_MOV, 1'b1, 16'h0080, 16'hFFFF));
    it = mk_op(mcalu_pkg::FN_MOV, 1'b1, 16'h0080, 16'h1234);
    it.dreg = 1'b0;
    op_pending.push_back(it);
    // byte bit ignored on word-only operations
    op_pending.push_back(mk_op(mcalu_pkg::FN_ADD, 1'b1, 16'hFFFF, 16'h0001));
    op_pending.push_back(mk_op(mcalu_pkg::FN_SUB, 1'b0, 16'h0001, 16'h8000));
    op_pending.push_back(mk_op(mcalu_pkg::FN_CMP, 1'b1, 16'h0000, 16'h00FF));
    op_pending.push_back(mk_op(mcalu_pkg::FN_BIT, 1'b0, 16'hFFFF, 16'h8000));
    op_pending.push_back(mk_op(mcalu_pkg::FN_BIS, 1'b1, 16'h00F0, 16'hFF0F));
    op_pending.push_back(mk_op(mcalu_pkg::FN_BIC, 1'b0, 16'hFFFF, 16'h7FFF));
    op_pending.push_back(mk_op(mcalu_pkg::FN_XOR, 1'b1, 16'hFFFF, 16'h5555));
    op_pending.push_back(mk_op(mcalu_pkg::FN_CCSET, 1'b0, 16'h0000, 16'h0000));
    // always-branch: never taken on sense 0, always on sense 1
    op_pending.push_back(mk_op(mcalu_pkg::FN_BRANCH, 1'b0, 16'h0000, 16'h0000));
    it = mk_op(mcalu_pkg::FN_BRANCH, 1'b0, 16'h0000, 16'h0000);
    it.sense = 1'b1;
    op_pending.push_back(it);
    op_pending.push_back(mk_op(FN_NOP_LAST, 1'b1, 16'hFFFF, 16'hFFFF));

    // random part, with a full drain of the pipe every so often
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      it = rand_op();
      it.drain = (i % DRAIN_EVERY == 0);
      op_pending.push_back(it);
    end

    // reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // wait for everything sent and returned, sampled away from the clock edge
    @(negedge clk);
    while (op_pending.size() > 0 || in_push || alu_expected.size() > 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    if (n_errors == 0) begin
      $display("tb_minicomputer_alu_condition_codes_top: PASS");
    end else begin
      $display("tb_minicomputer_alu_condition_codes_top: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mcalu_pkg.sv
rtl/mcalu_front.sv
rtl/mcalu_cmd_q.sv
rtl/mcalu_back.sv
rtl/minicomputer_alu_condition_codes_top.sv
test/tb_minicomputer_alu_condition_codes_top.sv
